// ===== design/timestamp_hold_reorder_buffer_unit_assert.svh =====
// Assertion macros for the timestamp hold reorder buffer checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef TIMESTAMP_HOLD_REORDER_BUFFER_UNIT_ASSERT_SVH
`define TIMESTAMP_HOLD_REORDER_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define THRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define THRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/thrb_pkg.sv =====
// Shared constants, codes and types of the timestamp hold reorder buffer.
// No dependencies.
`timescale 1ns / 1ps

package thrb_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int TIME_W = 53;
    localparam int ID_W   = 22;
    localparam int CPU_W  = 10;
    localparam int KIND_W = 2;
    localparam int RK_W   = 3;
    localparam int RCNT_W = 6;
    localparam int TRY_W  = 4;
    localparam int HOLD_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_EXPIRE = 1'b1;

    localparam logic [RK_W-1:0] RK_INSERTED  = 3'd0;
    localparam logic [RK_W-1:0] RK_FULL      = 3'd1;
    localparam logic [RK_W-1:0] RK_COLLIDED  = 3'd2;
    localparam logic [RK_W-1:0] RK_RELEASED  = 3'd3;
    localparam logic [RK_W-1:0] RK_DONE      = 3'd4;

    // Register index is paddr[2]
    localparam logic REG_HOLD = 1'b0;
    localparam logic REG_BUMP = 1'b1;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd1000000000;
    localparam logic [TRY_W-1:0]  BUMP_RESET = 4'd10;

    typedef struct packed {
        logic [TIME_W-1:0] time_ns;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [CPU_W-1:0]  cpu;
        logic [KIND_W-1:0] kind;
    } entry_t;

    typedef struct packed {
        logic shift_in;
        logic shift_left;
    } cell_ctl_t;

endpackage

// ===== design/thrb_cell.sv =====
// One slot of the sorted event chain: holds an entry, compares it with the
// broadcast key and trades entries with its neighbors. Depends on thrb_pkg.
`timescale 1ns / 1ps

module thrb_cell
(
    input  logic                       clk,
    input  thrb_pkg::cell_ctl_t        ctl,
    input  logic [thrb_pkg::TIME_W-1:0] key,
    input  logic                       occupied,
    input  logic                       left_less,
    input  thrb_pkg::entry_t           left_entry,
    input  thrb_pkg::entry_t           right_entry,
    input  thrb_pkg::entry_t           new_entry,
    output thrb_pkg::entry_t           entry,
    output logic                       less,
    output logic                       hit
);

    thrb_pkg::entry_t entry_reg;
    thrb_pkg::entry_t entry_next;

    assign entry = entry_reg;
    assign less  = occupied && (entry_reg.time_ns < key);
    assign hit   = occupied && (entry_reg.time_ns == key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_in && !less)
        begin
            // first slot not below the key takes the new item, the rest move up
            entry_next = left_less ? new_entry : left_entry;
        end
        else if (ctl.shift_left)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/timestamp_hold_reorder_buffer_unit.sv =====
// Timestamp hold reorder buffer: top level with control, config and output.
// Depends on thrb_pkg and thrb_cell.
`timescale 1ns / 1ps

// Keeps up to CAPACITY process events sorted by unique timestamp in a chain
// of cells, cell 0 holding the oldest. An insert item (req_type 0) probes the
// whole chain for its timestamp once per cycle, bumping the timestamp by one
// after each hit, for at most max_bump_attempts probes (0 counts as 1); it
// then shifts the younger entries up one cell and drops the event in. It
// yields one result: inserted (with the final timestamp), rejected full or
// rejected collisions (both with the original timestamp). An expire item
// (req_type 1) releases events from cell 0 while their age now_time - time
// (zero for future stamps) is at least hold_time_ns, one result per cycle
// while the output slot is free, shifting the chain down by one each time,
// then closes with an expire done result carrying the count. The item is
// taken in the idle state; an insert then runs its probes and a placement
// step, a collision reject ends on its last probe, and a full reject is
// given in place of the first probe. The pace is set by the single shared
// probe key broadcast to all cells and by the one-deep output register,
// which hands on one result per cycle while the receiver keeps taking them.
// A new item is taken only between items, but may be taken while the last
// result still waits in the output register. Stored entries have no reset
// and need no clearing pass; the entry count alone marks which cells hold
// events. Registers: hold_time_ns at 0x0, max_bump_attempts at 0x4.

module timestamp_hold_reorder_buffer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [thrb_pkg::TIME_W-1:0]   event_time,
    input  logic [thrb_pkg::TIME_W-1:0]   now_time,
    input  logic [thrb_pkg::ID_W-1:0]     event_pid,
    input  logic [thrb_pkg::ID_W-1:0]     event_tid,
    input  logic [thrb_pkg::CPU_W-1:0]    event_cpu,
    input  logic [thrb_pkg::KIND_W-1:0]   event_kind,

    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [thrb_pkg::RK_W-1:0]     result_kind,
    output logic [thrb_pkg::TIME_W-1:0]   out_time,
    output logic [thrb_pkg::ID_W-1:0]     out_pid,
    output logic [thrb_pkg::ID_W-1:0]     out_tid,
    output logic [thrb_pkg::CPU_W-1:0]    out_cpu,
    output logic [thrb_pkg::KIND_W-1:0]   out_kind,
    output logic [thrb_pkg::RCNT_W-1:0]   released_count,
    output logic                          last,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thrb_pkg::ADDR_W-1:0]   paddr,
    input  logic [thrb_pkg::DATA_W-1:0]   pwdata,
    output logic [thrb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PROBE  = 2'd1;
    localparam logic [1:0] S_PLACE  = 2'd2;
    localparam logic [1:0] S_EXPIRE = 2'd3;

    // ---------------- control state ----------------
    logic [1:0]                    state_reg, state_next;
    logic [thrb_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [thrb_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [thrb_pkg::TRY_W-1:0]    tries_reg, tries_next;
    logic                          res_valid_reg, res_valid_next;
    logic [thrb_pkg::HOLD_W-1:0]   hold_reg;
    logic [thrb_pkg::TRY_W-1:0]    bump_reg;

    // ---------------- payload registers ----------------
    logic [thrb_pkg::TIME_W-1:0]   key_reg, key_next;
    logic [thrb_pkg::TIME_W-1:0]   now_reg;
    thrb_pkg::entry_t              new_entry_reg;
    thrb_pkg::entry_t              place_entry;

    logic [thrb_pkg::RK_W-1:0]     rkind_reg, rkind_next;
    thrb_pkg::entry_t              oentry_reg, oentry_next;
    logic [thrb_pkg::RCNT_W-1:0]   rcount_reg, rcount_next;
    logic                          last_reg, last_next;
    logic                          load_out;

    // ---------------- chain ----------------
    thrb_pkg::cell_ctl_t           ctl;
    thrb_pkg::entry_t              cell_entry [thrb_pkg::CAPACITY];
    logic [thrb_pkg::CAPACITY-1:0] less_vec;
    logic [thrb_pkg::CAPACITY-1:0] hit_vec;

    logic accept;
    logic slot_free;
    logic full;
    logic any_hit;
    logic release_ok;
    logic cfg_write;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !res_valid_reg || res_ready;
    assign full      = (count_reg == thrb_pkg::CNT_W'(thrb_pkg::CAPACITY));
    assign any_hit   = |hit_vec;

    // Cell 0 is the oldest entry; release it when old enough.
    always_comb
    begin
        if (cell_entry[0].time_ns > now_reg)
        begin
            release_ok = (hold_reg == '0);
        end
        else
        begin
            release_ok = ((now_reg - cell_entry[0].time_ns)
                          >= thrb_pkg::TIME_W'(hold_reg));
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < thrb_pkg::CAPACITY; gi++)
        begin : g_cell
            thrb_pkg::entry_t left_e;
            thrb_pkg::entry_t right_e;
            logic             left_l;

            if (gi == 0)
            begin : g_first
                // nothing below cell 0: it takes the new item when not less
                assign left_e = place_entry;
                assign left_l = 1'b1;
            end
            else
            begin : g_inner
                assign left_e = cell_entry[gi-1];
                assign left_l = less_vec[gi-1];
            end

            if (gi == thrb_pkg::CAPACITY - 1)
            begin : g_top
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_below
                assign right_e = cell_entry[gi+1];
            end

            thrb_cell u_cell
            (
                .clk         (clk),
                .ctl         (ctl),
                .key         (key_reg),
                .occupied    (thrb_pkg::CNT_W'(gi) < count_reg),
                .left_less   (left_l),
                .left_entry  (left_e),
                .right_entry (right_e),
                .new_entry   (place_entry),
                .entry       (cell_entry[gi]),
                .less        (less_vec[gi]),
                .hit         (hit_vec[gi])
            );
        end
    endgenerate

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        tries_next  = tries_reg;
        key_next    = key_reg;
        ctl         = '0;
        load_out    = 1'b0;
        rkind_next  = rkind_reg;
        oentry_next = '0;
        rcount_next = '0;
        last_next   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next   = event_time;
                    n_next     = '0;
                    tries_next = (bump_reg == '0) ? thrb_pkg::TRY_W'(1) : bump_reg;
                    state_next = (req_type == thrb_pkg::REQ_EXPIRE) ? S_EXPIRE : S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (full)
                begin
                    if (slot_free)
                    begin
                        load_out                = 1'b1;
                        rkind_next              = thrb_pkg::RK_FULL;
                        oentry_next.time_ns     = new_entry_reg.time_ns;
                        state_next              = S_IDLE;
                    end
                end
                else if (any_hit)
                begin
                    if (tries_reg <= thrb_pkg::TRY_W'(1))
                    begin
                        if (slot_free)
                        begin
                            load_out            = 1'b1;
                            rkind_next          = thrb_pkg::RK_COLLIDED;
                            oentry_next.time_ns = new_entry_reg.time_ns;
                            state_next          = S_IDLE;
                        end
                    end
                    else
                    begin
                        // bump and probe again; wraps at the top of the range
                        key_next   = key_reg + thrb_pkg::TIME_W'(1);
                        tries_next = tries_reg - thrb_pkg::TRY_W'(1);
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (slot_free)
                begin
                    ctl.shift_in        = 1'b1;
                    count_next          = count_reg + thrb_pkg::CNT_W'(1);
                    load_out            = 1'b1;
                    rkind_next          = thrb_pkg::RK_INSERTED;
                    oentry_next.time_ns = key_reg;
                    state_next          = S_IDLE;
                end
            end
            S_EXPIRE:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if ((count_reg != '0) && release_ok)
                    begin
                        ctl.shift_left = 1'b1;
                        count_next     = count_reg - thrb_pkg::CNT_W'(1);
                        n_next         = n_reg + thrb_pkg::CNT_W'(1);
                        rkind_next     = thrb_pkg::RK_RELEASED;
                        oentry_next    = cell_entry[0];
                        last_next      = 1'b0;
                    end
                    else
                    begin
                        rkind_next  = thrb_pkg::RK_DONE;
                        rcount_next = thrb_pkg::RCNT_W'(n_reg);
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken; a new one may replace it in the same cycle.
    always_comb
    begin
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            tries_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            tries_reg     <= tries_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // The held item keeps the original timestamp for the reject results.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (accept)
        begin
            now_reg               <= now_time;
            new_entry_reg.time_ns <= event_time;
            new_entry_reg.pid     <= event_pid;
            new_entry_reg.tid     <= event_tid;
            new_entry_reg.cpu     <= event_cpu;
            new_entry_reg.kind    <= event_kind;
        end
        if (load_out)
        begin
            rkind_reg  <= rkind_next;
            oentry_reg <= oentry_next;
            rcount_reg <= rcount_next;
            last_reg   <= last_next;
        end
    end

    // The placed entry's timestamp is the final probe key.
    always_comb
    begin
        place_entry         = new_entry_reg;
        place_entry.time_ns = key_reg;
    end

    assign res_valid      = res_valid_reg;
    assign result_kind    = rkind_reg;
    assign out_time       = oentry_reg.time_ns;
    assign out_pid        = oentry_reg.pid;
    assign out_tid        = oentry_reg.tid;
    assign out_cpu        = oentry_reg.cpu;
    assign out_kind       = oentry_reg.kind;
    assign released_count = rcount_reg;
    assign last           = last_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= thrb_pkg::HOLD_RESET;
            bump_reg <= thrb_pkg::BUMP_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                thrb_pkg::REG_HOLD: hold_reg <= pwdata;
                thrb_pkg::REG_BUMP: bump_reg <= pwdata[thrb_pkg::TRY_W-1:0];
                default:            hold_reg <= hold_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            thrb_pkg::REG_HOLD: prdata = hold_reg;
            thrb_pkg::REG_BUMP: prdata = thrb_pkg::DATA_W'(bump_reg);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== design/thrb_checker.sv =====
// Port-level checks on the result channel of the reorder buffer, bound to
// the top level. Depends on thrb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "timestamp_hold_reorder_buffer_unit_assert.svh"

module thrb_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  logic [thrb_pkg::RK_W-1:0]     result_kind,
    input  logic [thrb_pkg::TIME_W-1:0]   out_time,
    input  logic [thrb_pkg::ID_W-1:0]     out_pid,
    input  logic [thrb_pkg::ID_W-1:0]     out_tid,
    input  logic [thrb_pkg::CPU_W-1:0]    out_cpu,
    input  logic [thrb_pkg::KIND_W-1:0]   out_kind,
    input  logic [thrb_pkg::RCNT_W-1:0]   released_count,
    input  logic                          last
);

    // A stalled result holds.
    `THRB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(result_kind) && $stable(out_time) && $stable(released_count) && $stable(last), "stalled result changed")

    // Only released events leave last low.
    `THRB_ASSERT_NOW(a_last_kind, res_valid, last == (result_kind != thrb_pkg::RK_RELEASED), "last flag does not match result kind")

    // Count shows only on expire done.
    `THRB_ASSERT_NOW(a_count_done, res_valid && (result_kind != thrb_pkg::RK_DONE), released_count == '0, "released count outside expire done")

    // Event payload shows only on released events.
    `THRB_ASSERT_NOW(a_payload_zero, res_valid && (result_kind != thrb_pkg::RK_RELEASED), (out_pid == '0) && (out_tid == '0) && (out_cpu == '0) && (out_kind == '0), "payload set outside a released event")

endmodule

bind timestamp_hold_reorder_buffer_unit thrb_checker u_thrb_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .result_kind    (result_kind),
    .out_time       (out_time),
    .out_pid        (out_pid),
    .out_tid        (out_tid),
    .out_cpu        (out_cpu),
    .out_kind       (out_kind),
    .released_count (released_count),
    .last           (last)
);

// ===== tb/sv/timestamp_hold_reorder_buffer_unit_test.sv =====
// Self-checking bench for timestamp_hold_reorder_buffer_unit: directed and random
// insert/expire items, APB register writes, random idling on both channels.
// Depends on thrb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module timestamp_hold_reorder_buffer_unit_test;

    import thrb_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};
    localparam logic [CPU_W-1:0]  CPU_MAX  = {CPU_W{1'b1}};
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
    localparam logic [ADDR_W-1:0] HOLD_ADDR = {REG_HOLD, 2'b00};
    localparam logic [ADDR_W-1:0] BUMP_ADDR = {REG_BUMP, 2'b00};

    typedef struct {
        logic              req_type;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] now_time;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [CPU_W-1:0]  cpu;
        logic [KIND_W-1:0] kind;
    } buffer_req_t;

    typedef struct {
        logic [RK_W-1:0]   kind;
        logic [TIME_W-1:0] time_ns;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   tid;
        logic [CPU_W-1:0]  cpu;
        logic [KIND_W-1:0] ekind;
        logic [RCNT_W-1:0] count;
        logic              last_flag;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              req_valid = 1'b0;
    logic              req_ready;
    logic              req_type = REQ_INSERT;
    logic [TIME_W-1:0] event_time = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic [ID_W-1:0]   event_pid = '0;
    logic [ID_W-1:0]   event_tid = '0;
    logic [CPU_W-1:0]  event_cpu = '0;
    logic [KIND_W-1:0] event_kind = '0;

    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [RK_W-1:0]   result_kind;
    logic [TIME_W-1:0] out_time;
    logic [ID_W-1:0]   out_pid;
    logic [ID_W-1:0]   out_tid;
    logic [CPU_W-1:0]  out_cpu;
    logic [KIND_W-1:0] out_kind;
    logic [RCNT_W-1:0] released_count;
    logic              last;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b1;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    timestamp_hold_reorder_buffer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .event_time     (event_time),
        .now_time       (now_time),
        .event_pid      (event_pid),
        .event_tid      (event_tid),
        .event_cpu      (event_cpu),
        .event_kind     (event_kind),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .result_kind    (result_kind),
        .out_time       (out_time),
        .out_pid        (out_pid),
        .out_tid        (out_tid),
        .out_cpu        (out_cpu),
        .out_kind       (out_kind),
        .released_count (released_count),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Shadow of the block: sorted event store and the two registers.
    entry_t            held_events[CAPACITY];
    int                held_count = 0;
    logic [HOLD_W-1:0] hold_copy = HOLD_RESET;
    logic [TRY_W-1:0]  bump_limit = BUMP_RESET;

    buffer_req_t pending_requests[$];
    outcome_t    due_outcomes[$];
    int          bad_fields = 0;

    // Sender and receiver state, shared between the edge blocks.
    buffer_req_t active_req = '{REQ_INSERT, '0, '0, '0, '0, '0, '0};
    bit          sending = 1'b0;
    bit          req_taken = 1'b0;
    bit          drain_before_next = 1'b0;
    int          send_gap = 0;
    int          send_gap_max = 12;
    bit          res_taken = 1'b0;
    int          res_stall = 0;
    int          stall_max = 12;

    function automatic logic [TIME_W-1:0] any_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Work out what one accepted item makes the block emit, and update the shadow store.
    function automatic void run_buffer_request(buffer_req_t r);
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] age;
        int                tries, a, i, pos, n;
        bit                placed, hit;
        outcome_t          o;
        o = '{default: '0};
        if (r.req_type == REQ_INSERT)
        begin
            o.last_flag = 1'b1;
            o.time_ns = r.event_time;
            // A full store rejects before any collision probe.
            if (held_count >= CAPACITY)
            begin
                o.kind = RK_FULL;
                due_outcomes.push_back(o);
                return;
            end
            tries = (bump_limit == 0) ? 1 : int'(bump_limit);
            stamp = r.event_time;
            placed = 1'b0;
            for (a = 0; a < tries && !placed; a++)
            begin
                hit = 1'b0;
                for (i = 0; i < held_count; i++)
                    if (held_events[i].time_ns == stamp)
                        hit = 1'b1;
                if (hit)
                    stamp = stamp + TIME_W'(1);   // wraps at 53 bits
                else
                    placed = 1'b1;
            end
            if (!placed)
            begin
                o.kind = RK_COLLIDED;
                due_outcomes.push_back(o);
                return;
            end
            pos = 0;
            while (pos < held_count && held_events[pos].time_ns < stamp)
                pos++;
            for (i = held_count; i > pos; i--)
                held_events[i] = held_events[i-1];
            held_events[pos] = '{stamp, r.pid, r.tid, r.cpu, r.kind};
            held_count++;
            o.kind = RK_INSERTED;
            o.time_ns = stamp;
            due_outcomes.push_back(o);
        end
        else
        begin
            // Release from the oldest end while the age reaches the hold time.
            n = 0;
            while (n < held_count)
            begin
                age = (held_events[n].time_ns > r.now_time) ? '0
                                                             : r.now_time - held_events[n].time_ns;
                if (age < TIME_W'(hold_copy))
                    break;
                o.kind = RK_RELEASED;
                o.time_ns = held_events[n].time_ns;
                o.pid = held_events[n].pid;
                o.tid = held_events[n].tid;
                o.cpu = held_events[n].cpu;
                o.ekind = held_events[n].kind;
                o.last_flag = 1'b0;
                due_outcomes.push_back(o);
                n++;
            end
            for (i = n; i < held_count; i++)
                held_events[i-n] = held_events[i];
            held_count -= n;
            o = '{default: '0};
            o.kind = RK_DONE;
            o.count = RCNT_W'(n);
            o.last_flag = 1'b1;
            due_outcomes.push_back(o);
        end
    endfunction

    function automatic void compare_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
            bad_fields++;
        end
    endfunction

    // Sender, accept side: predict on the edge that takes the item.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            run_buffer_request(active_req);
            req_taken = 1'b1;
        end
    end

    // Sender, drive side: retire the taken item, idle, then present the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                sending = 1'b0;
                send_gap = $urandom_range(0, send_gap_max);
                // Now and then hold off until the block has emptied out.
                drain_before_next = ($urandom_range(0, 15) == 0);
            end
            if (!sending)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_requests.size() > 0 &&
                         !(drain_before_next && due_outcomes.size() > 0))
                begin
                    active_req = pending_requests.pop_front();
                    sending = 1'b1;
                end
            end
            req_valid  <= sending;
            req_type   <= active_req.req_type;
            event_time <= active_req.event_time;
            now_time   <= active_req.now_time;
            event_pid  <= active_req.pid;
            event_tid  <= active_req.tid;
            event_cpu  <= active_req.cpu;
            event_kind <= active_req.kind;
        end
    end

    // Receiver: stall a random number of cycles after each result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                res_stall = $urandom_range(0, stall_max);
            end
            if (res_stall > 0)
            begin
                res_stall--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Monitor: compare every taken result with the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_valid && res_ready)
        begin
            res_taken = 1'b1;
            if (due_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind 0x%0h time 0x%0h",
                         $time, result_kind, out_time);
                bad_fields++;
            end
            else
            begin
                want = due_outcomes.pop_front();
                compare_field("result_kind", 64'(want.kind), 64'(result_kind));
                compare_field("out_time", 64'(want.time_ns), 64'(out_time));
                compare_field("out_pid", 64'(want.pid), 64'(out_pid));
                compare_field("out_tid", 64'(want.tid), 64'(out_tid));
                compare_field("out_cpu", 64'(want.cpu), 64'(out_cpu));
                compare_field("out_kind", 64'(want.ekind), 64'(out_kind));
                compare_field("released_count", 64'(want.count), 64'(released_count));
                compare_field("last", 64'(want.last_flag), 64'(last));
            end
        end
    end

    task automatic queue_insert(logic [TIME_W-1:0] t, logic [ID_W-1:0] pid,
                                logic [ID_W-1:0] tid, logic [CPU_W-1:0] cpu,
                                logic [KIND_W-1:0] kind);
        buffer_req_t r;
        // now_time is ignored on insert; fill it with noise anyway.
        r = '{REQ_INSERT, t, any_stamp(), pid, tid, cpu, kind};
        pending_requests.push_back(r);
    endtask

    task automatic queue_expire(logic [TIME_W-1:0] now);
        buffer_req_t r;
        r = '{REQ_EXPIRE, any_stamp(), now, ID_W'($urandom), ID_W'($urandom),
              CPU_W'($urandom), KIND_W'($urandom)};
        pending_requests.push_back(r);
    endtask

    task automatic queue_random_insert(logic [TIME_W-1:0] t);
        queue_insert(t, ID_W'($urandom), ID_W'($urandom), CPU_W'($urandom),
                     KIND_W'($urandom_range(0, 3)));
    endtask

    // Wait until every item is taken and every result is back, then let the block settle.
    task automatic wait_idle();
        while (pending_requests.size() > 0 || sending || due_outcomes.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == HOLD_ADDR)
            hold_copy = data;
        else
            bump_limit = data[TRY_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the block idle; junk in the upper bump bits is ignored.
    task automatic set_registers(logic [HOLD_W-1:0] hold, logic [TRY_W-1:0] bump);
        logic [DATA_W-1:0] junk;
        wait_idle();
        junk = $urandom;
        write_reg(HOLD_ADDR, hold);
        write_reg(BUMP_ADDR, {junk[DATA_W-1:TRY_W], bump});
    endtask

    // Random stretch around a base time: clustered stamps for collisions, expire
    // times near base + hold so that part of the store gets released.
    task automatic run_random_stretch(logic [HOLD_W-1:0] hold, logic [TRY_W-1:0] bump,
                                      logic [TIME_W-1:0] base, int spread, int count,
                                      int insert_pct, int gap_max, int stall_lim);
        logic [TIME_W-1:0] t;
        int                k;
        set_registers(hold, bump);
        send_gap_max = gap_max;
        stall_max = stall_lim;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < insert_pct)
            begin
                if ($urandom_range(0, 9) == 0)
                    t = any_stamp();
                else
                    t = base + TIME_W'($urandom_range(0, spread));
                queue_random_insert(t);
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    t = any_stamp();
                else
                    t = base + TIME_W'(hold) + TIME_W'($urandom_range(0, 2 * spread))
                        - TIME_W'(spread);
                queue_expire(t);
            end
        end
        // Flush: zero hold releases everything left over.
        set_registers('0, bump);
        queue_expire(any_stamp());
        wait_idle();
    endtask

    initial
    begin
        logic [TIME_W-1:0] base;
        int                p;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset register values: empty expire, payload extremes,
        // bumping, every kind code including 3, and a bump past the top stamp.
        queue_expire('0);
        queue_insert(TIME_W'(100), ID_MAX, '0, CPU_MAX, 2'd0);
        queue_insert(TIME_W'(100), '0, ID_MAX, '0, 2'd1);
        queue_insert(TIME_W'(100), ID_MAX, ID_MAX, CPU_MAX, 2'd2);
        queue_insert(TIME_MAX, '0, '0, '0, 2'd3);
        queue_insert(TIME_MAX, ID_MAX, '0, '0, 2'd1);
        queue_expire(TIME_MAX);

        // Single try: a collision rejects at once; zero hold drains future stamps too.
        set_registers('0, 4'd1);
        queue_insert(TIME_MAX, '0, ID_MAX, CPU_MAX, 2'd0);
        queue_insert(TIME_W'(5), ID_MAX, ID_MAX, '0, 2'd2);
        queue_expire('0);

        // Bump value zero behaves as one try; maximum hold releases on the exact age only.
        set_registers(HOLD_MAX, 4'd0);
        queue_insert(TIME_W'(7), ID_W'(1), ID_W'(2), CPU_W'(3), 2'd3);
        queue_insert(TIME_W'(7), ID_W'(4), ID_W'(5), CPU_W'(6), 2'd0);
        queue_expire(TIME_W'(7) + TIME_W'(HOLD_MAX) - TIME_W'(1));
        queue_expire(TIME_W'(7) + TIME_W'(HOLD_MAX));

        // Two tries: the third insert at one stamp runs out of tries.
        set_registers('0, 4'd2);
        queue_insert(TIME_W'(50), ID_W'($urandom), ID_W'($urandom), CPU_W'($urandom), 2'd1);
        queue_insert(TIME_W'(50), ID_W'($urandom), ID_W'($urandom), CPU_W'($urandom), 2'd2);
        queue_insert(TIME_W'(50), ID_W'($urandom), ID_W'($urandom), CPU_W'($urandom), 2'd0);
        queue_expire('0);
        wait_idle();

        for (p = 0; p < 6; p++)
        begin
            base = any_stamp() >> 1;
            case (p)
                0: run_random_stretch('0, 4'd15, base, 30, 15, 60, 12, 12);
                1: run_random_stretch(HOLD_MAX, 4'd1, base, 30, 25, 65, 12, 0);
                // No idling on either side.
                2: run_random_stretch(HOLD_W'($urandom_range(0, 100)),
                                      TRY_W'($urandom_range(1, 15)), base, 40, 15, 60, 0, 0);
                // Inserts only into a narrow window: fills the store and runs out of tries.
                3: run_random_stretch(HOLD_MAX, 4'd15, base, 20, 40, 100, 3, 3);
                4: run_random_stretch(HOLD_W'($urandom), TRY_W'($urandom_range(0, 15)),
                                      base, 30, 25, 55, 0, 12);
                // Stamps just below the top, so bumps and offsets wrap around.
                default: run_random_stretch(HOLD_W'($urandom_range(0, 40)), 4'd15,
                                            TIME_MAX - TIME_W'(25), 40, 20, 60, 12, 12);
            endcase
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (bad_fields == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/thrb_pkg.sv
design/thrb_cell.sv
design/timestamp_hold_reorder_buffer_unit.sv
design/thrb_checker.sv
tb/sv/timestamp_hold_reorder_buffer_unit_test.sv
